### rtl/core/llbs_pkg.sv
`timescale 1ns / 1ps

package llbs_pkg;

    // sizing of the bin set and of one sequence
    localparam int MAX_BINS  = 8;
    localparam int MAX_ITEMS = 32;

    // fixed field widths
    localparam int VALUE_W  = 16;
    localparam int CFG_W    = 4;
    localparam int SPREAD_W = 46;
    localparam int TOTAL_W  = 21;

    // derived internal widths
    localparam int BIN_IDX_W = $clog2(MAX_BINS);
    localparam int M_W       = ($clog2(MAX_BINS + 1) > CFG_W) ? $clog2(MAX_BINS + 1) : CFG_W;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int LOAD_W    = VALUE_W + $clog2(MAX_ITEMS);
    localparam int SQ_W      = 2 * LOAD_W;
    localparam int SUMSQ_W   = SQ_W + BIN_IDX_W;
    localparam int LHS_W     = SUMSQ_W + M_W;

    // reset value of the bin count register
    localparam logic [CFG_W-1:0] BIN_COUNT_RESET = CFG_W'(2);

    typedef struct packed {
        logic [VALUE_W-1:0] item_value;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [SPREAD_W-1:0] spread;
        logic [TOTAL_W-1:0]  total;
    } result_t;

endpackage

### rtl/core/llbs_square.sv
`timescale 1ns / 1ps

module llbs_square
    import llbs_pkg::*;
(
    input  logic              clk,
    input  logic [LOAD_W-1:0] a,
    output logic [SQ_W-1:0]   sq
);

    // registered squarer shared by the load and total passes
    always_ff @(posedge clk)
    begin
        sq <= SQ_W'(a) * SQ_W'(a);
    end

endmodule

### rtl/core/least_loaded_bin_spread.sv
`timescale 1ns / 1ps

// least_loaded_bin_spread
// input channel: item (weight and last flag) is taken at a clock edge with
// start high and busy low. each weight is added to the least-loaded bin in
// use, ties going to the lowest index. busy stays high while the item works.
// result channel: on the item marked last, done pulses for one cycle with
// result holding spread = m*sum(load^2) - total^2 and the total, while the
// bin state is cleared. the receiver cannot stall, so no result is held.
// config: cfg_we/cfg_wdata write the bin count m (0 reads as 1, values above
// the bin limit read as the limit); write only while idle.
// sequence: a non-last item keeps busy high through the search step (the
// shared comparator walking the loads) and the add step; the next item is
// taken only after that. a last item then passes through the shared squarer
// for each load, then the total square, scaling and a finish step, which
// raises done. once the item limit is reached, weights are dropped and a
// non-last item is taken without raising busy.
// reset: rst_n clears all loads, the total and the item count, and sets m=2.

module least_loaded_bin_spread
    import llbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             done,
    output result_t          result,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SEARCH = 7'b0000010,
        ST_ADD    = 7'b0000100,
        ST_SQUARE = 7'b0001000,
        ST_TOTSQ  = 7'b0010000,
        ST_SCALE  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    // control state
    state_t             state_reg, state_next;
    logic               done_reg, done_next;
    logic               acc_en_reg, acc_en_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LOAD_W-1:0]  loads_reg [MAX_BINS];
    logic [LOAD_W-1:0]  loads_next [MAX_BINS];
    logic [LOAD_W-1:0]  total_reg, total_next;
    logic [CFG_W-1:0]   bin_count_reg, bin_count_next;

    // payload state
    logic [VALUE_W-1:0]   weight_reg, weight_next;
    logic                 last_reg, last_next;
    logic [BIN_IDX_W-1:0] best_reg, best_next;
    logic [LOAD_W-1:0]    best_load_reg, best_load_next;
    logic [BIN_IDX_W-1:0] idx_reg, idx_next;
    logic [SUMSQ_W-1:0]   sumsq_reg, sumsq_next;
    logic [LHS_W-1:0]     lhs_reg, lhs_next;
    logic [LHS_W-1:0]     rhs_reg, rhs_next;
    result_t              result_reg, result_next;

    logic [M_W-1:0]       cfg_ext;
    logic [M_W-1:0]       m;
    logic [BIN_IDX_W-1:0] last_idx;
    logic [LOAD_W-1:0]    load_rd;
    logic [LOAD_W-1:0]    mul_a;
    logic [SQ_W-1:0]      prod;

    // bins in use, clamped to the legal range
    always_comb
    begin
        cfg_ext = M_W'(bin_count_reg);
        if (cfg_ext == '0)
            m = M_W'(1);
        else if (cfg_ext > M_W'(MAX_BINS))
            m = M_W'(MAX_BINS);
        else
            m = cfg_ext;
        last_idx = BIN_IDX_W'(m - M_W'(1));
    end

    assign load_rd = loads_reg[idx_reg];

    llbs_square u_square (
        .clk (clk),
        .a   (mul_a),
        .sq  (prod)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        acc_en_next    = 1'b0;
        count_next     = count_reg;
        loads_next     = loads_reg;
        total_next     = total_reg;
        bin_count_next = cfg_we ? cfg_wdata : bin_count_reg;
        weight_next    = weight_reg;
        last_next      = last_reg;
        best_next      = best_reg;
        best_load_next = best_load_reg;
        idx_next       = idx_reg;
        sumsq_next     = sumsq_reg;
        lhs_next       = lhs_reg;
        rhs_next       = rhs_reg;
        result_next    = result_reg;
        mul_a          = load_rd;

        // squares arrive in the cycle after issue, from the registered squarer
        if (acc_en_reg)
            sumsq_next = sumsq_reg + SUMSQ_W'(prod);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    weight_next = item.item_value;
                    last_next   = item.last;
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        best_next      = '0;
                        best_load_next = loads_reg[0];
                        idx_next       = BIN_IDX_W'(1);
                        state_next     = (m == M_W'(1)) ? ST_ADD : ST_SEARCH;
                    end
                    else if (item.last)
                    begin
                        idx_next   = '0;
                        sumsq_next = '0;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SEARCH:
            begin
                // strict compare keeps the lowest index on ties
                if (load_rd < best_load_reg)
                begin
                    best_next      = idx_reg;
                    best_load_next = load_rd;
                end
                if (idx_reg == last_idx)
                    state_next = ST_ADD;
                else
                    idx_next = idx_reg + BIN_IDX_W'(1);
            end
            ST_ADD:
            begin
                loads_next[best_reg] = best_load_reg + LOAD_W'(weight_reg);
                total_next           = total_reg + LOAD_W'(weight_reg);
                count_next           = count_reg + CNT_W'(1);
                if (last_reg)
                begin
                    idx_next   = '0;
                    sumsq_next = '0;
                    state_next = ST_SQUARE;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_SQUARE:
            begin
                acc_en_next = 1'b1;
                if (idx_reg == last_idx)
                    state_next = ST_TOTSQ;
                else
                    idx_next = idx_reg + BIN_IDX_W'(1);
            end
            ST_TOTSQ:
            begin
                mul_a      = total_reg;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                lhs_next   = LHS_W'(sumsq_reg) * LHS_W'(m);
                rhs_next   = LHS_W'(prod);
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (lhs_reg >= rhs_reg)
                    result_next.spread = SPREAD_W'(lhs_reg - rhs_reg);
                else
                    result_next.spread = '0;
                result_next.total = TOTAL_W'(total_reg);
                done_next         = 1'b1;
                for (int i = 0; i < MAX_BINS; i++)
                    loads_next[i] = '0;
                total_next = '0;
                count_next = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            acc_en_reg    <= 1'b0;
            count_reg     <= '0;
            total_reg     <= '0;
            bin_count_reg <= BIN_COUNT_RESET;
            for (int i = 0; i < MAX_BINS; i++)
                loads_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            acc_en_reg    <= acc_en_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            bin_count_reg <= bin_count_next;
            loads_reg     <= loads_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        weight_reg    <= weight_next;
        last_reg      <= last_next;
        best_reg      <= best_next;
        best_load_reg <= best_load_next;
        idx_reg       <= idx_next;
        sumsq_reg     <= sumsq_next;
        lhs_reg       <= lhs_next;
        rhs_reg       <= rhs_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // result beat only follows the finish step
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_FINISH))
        else $error("result beat without finish step");

    // bin walk stays within the bins in use
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH || state_reg == ST_SQUARE) |-> (idx_reg <= last_idx))
        else $error("bin index beyond bins in use");

    // chosen bin is one of the bins in use
    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> (M_W'(best_reg) < m))
        else $error("selected bin beyond bins in use");

    // a weight under the item limit always goes to the search or add step
    a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && count_reg < CNT_W'(MAX_ITEMS))
        |=> (state_reg == ST_SEARCH || state_reg == ST_ADD))
        else $error("accepted beat did not start a search");
`endif

endmodule
